// ===== hw/rtl/motion_order_mixer_defines.svh =====
// Assertion macros shared by the motion order mixer checker.
`ifndef MOTION_ORDER_MIXER_DEFINES_SVH
`define MOTION_ORDER_MIXER_DEFINES_SVH

// Same-cycle implication, sampled on clk_i, off while rst_ni is low.
`define MOM_ASSERT_SAME(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on clk_i, off while rst_ni is low.
`define MOM_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== hw/rtl/mom_pkg.sv =====
// Types and constants of the motion order mixer.
`default_nettype none

package mom_pkg;

  localparam int PROGRAM_SLOTS = 3;
  localparam int SLOT_IDX_W    = (PROGRAM_SLOTS > 1) ? $clog2(PROGRAM_SLOTS) : 1;
  localparam int SLOT_PORT_W   = 4;
  localparam int VEL_W         = 16;
  localparam int KEY_W         = 16;
  localparam int TIME_W        = 32;
  localparam int SUM_W         = 19;
  // Joystick, API and every slot may add in.
  localparam int ACC_W         = VEL_W + 1 + $clog2(PROGRAM_SLOTS + 2);

  localparam logic signed [ACC_W-1:0] SUM_MAX_A = ACC_W'(2 ** (SUM_W - 1) - 1);
  localparam logic signed [ACC_W-1:0] SUM_MIN_A = ACC_W'(-(2 ** (SUM_W - 1)));

  localparam int IN_TDATA_W  = 104;
  localparam int IN_TUSER_W  = 3;
  localparam int OUT_TDATA_W = 64;

  typedef enum logic [2:0] {
    OP_SET_API     = 3'd0,
    OP_SET_JOY     = 3'd1,
    OP_SET_PROGRAM = 3'd2,
    OP_PROG_ENABLE = 3'd3,
    OP_ESTOP       = 3'd4,
    OP_QUERY       = 3'd5
  } op_e;

  typedef struct packed {
    logic signed [VEL_W-1:0] t;
    logic signed [VEL_W-1:0] y;
    logic signed [VEL_W-1:0] x;
  } vel_t;

  typedef struct packed {
    op_e               op;
    logic [KEY_W-1:0]  key;
    vel_t              vel;
    logic              en;
    logic [TIME_W-1:0] now;
  } mom_req_t;

  // Orders as they stand after the current request.
  typedef struct packed {
    logic                           api_en;
    vel_t                           api_vel;
    vel_t                           joy_vel;
    logic [PROGRAM_SLOTS-1:0]       slot_en;
    vel_t [PROGRAM_SLOTS-1:0]       slot_vel;
  } mom_view_t;

  typedef struct packed {
    logic                  matched;
    logic [SLOT_IDX_W-1:0] idx;
  } mom_hit_t;

endpackage

`default_nettype wire

// ===== hw/rtl/motion_order_mixer.sv =====
// Top level of the motion order mixer: request register, table, adder, result register.
//
//   channel   dir  tdata fields (lsb first)                          tuser
//   s_axis    in   program_key, velocity_x, velocity_y, turn_rate,   operation
//                  enable_flag, now_ms
//   m_axis    out  sum_x, sum_y, sum_turn, slot_index, key_matched   -
//
// One request per cycle, sustained while m_axis is not stalled. An accepted
// request waits in the request register and is applied to the table and
// written to the result register at the same edge, once the result register
// is free or being emptied.
// The table update, key lookup and five-term add all sit between the request
// register and the result register.
// Reset clears the table (all orders, keys, timestamps and enables) and both
// valid flags.
// A stalled result holds the request register; one more request is taken
// while the result waits, then s_axis_tready drops.
`default_nettype none

module motion_order_mixer (
  input  wire logic                            clk_i,
  input  wire logic                            rst_ni,
  input  wire logic                            s_axis_tvalid,
  output logic                                 s_axis_tready,
  // [15:0] program_key, [31:16] velocity_x, [47:32] velocity_y,
  // [63:48] turn_rate, [64] enable_flag, [96:65] now_ms, [103:97] zero
  input  wire logic [mom_pkg::IN_TDATA_W-1:0]  s_axis_tdata,
  // [2:0] operation
  input  wire logic [mom_pkg::IN_TUSER_W-1:0]  s_axis_tuser,
  output logic                                 m_axis_tvalid,
  input  wire logic                            m_axis_tready,
  // [18:0] sum_x, [37:19] sum_y, [56:38] sum_turn, [60:57] slot_index,
  // [61] key_matched, [63:62] zero
  output logic [mom_pkg::OUT_TDATA_W-1:0]      m_axis_tdata
);
  import mom_pkg::*;

  logic                   in_vld_q, in_vld_d;
  mom_req_t               in_req_q;
  logic                   out_vld_q, out_vld_d;
  logic [OUT_TDATA_W-1:0] out_data_q, out_data_d;

  logic                   s_acc;
  logic                   advance;
  mom_req_t               req_new;
  mom_view_t              view;
  mom_hit_t               hit;
  logic [SUM_W-1:0]       sum_x, sum_y, sum_t;

  // Apply the held request when the result register is free or being emptied.
  assign advance       = in_vld_q && (!out_vld_q || m_axis_tready);
  assign s_axis_tready = !in_vld_q || advance;
  assign s_acc         = s_axis_tvalid && s_axis_tready;

  // Unpack the incoming request.
  always_comb begin
    req_new.op  = op_e'(s_axis_tuser[2:0]);
    req_new.key = s_axis_tdata[15:0];
    req_new.vel = vel_t'(s_axis_tdata[63:16]);
    req_new.en  = s_axis_tdata[64];
    req_new.now = s_axis_tdata[96:65];
  end

  mom_table u_table (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .advance_i (advance),
    .req_i     (in_req_q),
    .view_o    (view),
    .hit_o     (hit)
  );

  mom_sum u_sum (
    .view_i  (view),
    .sum_x_o (sum_x),
    .sum_y_o (sum_y),
    .sum_t_o (sum_t)
  );

  always_comb begin
    in_vld_d = in_vld_q;
    if (s_acc) begin
      in_vld_d = 1'b1;
    end else if (advance) begin
      in_vld_d = 1'b0;
    end
  end

  always_comb begin
    out_vld_d  = out_vld_q;
    out_data_d = out_data_q;
    if (advance) begin
      out_vld_d  = 1'b1;
      out_data_d = {2'b00, hit.matched, SLOT_PORT_W'(hit.idx), sum_t, sum_y, sum_x};
    end else if (m_axis_tready) begin
      out_vld_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q  <= 1'b0;
      out_vld_q <= 1'b0;
    end else begin
      in_vld_q  <= in_vld_d;
      out_vld_q <= out_vld_d;
    end
  end

  // Payload registers: no reset.
  always_ff @(posedge clk_i) begin
    if (s_acc) begin
      in_req_q <= req_new;
    end
    out_data_q <= out_data_d;
  end

  assign m_axis_tvalid = out_vld_q;
  assign m_axis_tdata  = out_data_q;

endmodule

`default_nettype wire

// ===== hw/rtl/mom_table.sv =====
// Order table: key lookup, slot replacement and per-request state update.
`default_nettype none

module mom_table (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              advance_i,
  input  wire mom_pkg::mom_req_t req_i,
  output mom_pkg::mom_view_t     view_o,
  output mom_pkg::mom_hit_t      hit_o
);
  import mom_pkg::*;

  logic                                  api_en_q, api_en_d;
  vel_t                                  api_vel_q, api_vel_d;
  vel_t                                  joy_vel_q, joy_vel_d;
  logic [PROGRAM_SLOTS-1:0][KEY_W-1:0]   key_q, key_d;
  logic [PROGRAM_SLOTS-1:0]              key_vld_q, key_vld_d;
  logic [PROGRAM_SLOTS-1:0][TIME_W-1:0]  time_q, time_d;
  logic [PROGRAM_SLOTS-1:0]              en_q, en_d;
  vel_t [PROGRAM_SLOTS-1:0]              vel_q, vel_d;

  logic                  found;
  logic [SLOT_IDX_W-1:0] found_idx;
  logic [SLOT_IDX_W-1:0] old_idx;
  logic [TIME_W-1:0]     best_time;
  logic [SLOT_IDX_W-1:0] prog_idx;

  // Lowest valid slot holding the key.
  always_comb begin
    found     = 1'b0;
    found_idx = '0;
    for (int k = PROGRAM_SLOTS - 1; k >= 0; k--) begin
      if (key_vld_q[k] && (key_q[k] == req_i.key)) begin
        found     = 1'b1;
        found_idx = SLOT_IDX_W'(k);
      end
    end
  end

  // Least recent timestamp; ties go to the highest slot.
  always_comb begin
    old_idx   = '0;
    best_time = time_q[0];
    for (int k = 1; k < PROGRAM_SLOTS; k++) begin
      if (time_q[k] <= best_time) begin
        best_time = time_q[k];
        old_idx   = SLOT_IDX_W'(k);
      end
    end
  end

  assign prog_idx = found ? found_idx : old_idx;

  always_comb begin
    api_en_d  = api_en_q;
    api_vel_d = api_vel_q;
    joy_vel_d = joy_vel_q;
    key_d     = key_q;
    key_vld_d = key_vld_q;
    time_d    = time_q;
    en_d      = en_q;
    vel_d     = vel_q;
    hit_o     = '0;
    case (req_i.op)
      OP_SET_API: begin
        api_en_d  = 1'b1;
        api_vel_d = req_i.vel;
      end
      OP_SET_JOY: begin
        joy_vel_d = req_i.vel;
      end
      OP_SET_PROGRAM: begin
        key_d[prog_idx]     = req_i.key;
        key_vld_d[prog_idx] = 1'b1;
        en_d[prog_idx]      = 1'b1;
        time_d[prog_idx]    = req_i.now;
        vel_d[prog_idx]     = req_i.vel;
        hit_o.matched       = found;
        hit_o.idx           = prog_idx;
      end
      OP_PROG_ENABLE: begin
        if (found) begin
          en_d[found_idx] = req_i.en;
          hit_o.matched   = 1'b1;
          hit_o.idx       = found_idx;
        end
      end
      OP_ESTOP: begin
        api_en_d  = 1'b0;
        api_vel_d = '0;
        joy_vel_d = '0;
        en_d      = '0;
        vel_d     = '0;
      end
      default: begin
      end
    endcase
  end

  always_comb begin
    view_o.api_en   = api_en_d;
    view_o.api_vel  = api_vel_d;
    view_o.joy_vel  = joy_vel_d;
    view_o.slot_en  = en_d;
    view_o.slot_vel = vel_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      api_en_q  <= 1'b0;
      api_vel_q <= '0;
      joy_vel_q <= '0;
      key_q     <= '0;
      key_vld_q <= '0;
      time_q    <= '0;
      en_q      <= '0;
      vel_q     <= '0;
    end else if (advance_i) begin
      api_en_q  <= api_en_d;
      api_vel_q <= api_vel_d;
      joy_vel_q <= joy_vel_d;
      key_q     <= key_d;
      key_vld_q <= key_vld_d;
      time_q    <= time_d;
      en_q      <= en_d;
      vel_q     <= vel_d;
    end
  end

endmodule

`default_nettype wire

// ===== hw/rtl/mom_sum.sv =====
// Adder of the enabled orders with saturation to the result width.
`default_nettype none

module mom_sum (
  input  wire mom_pkg::mom_view_t        view_i,
  output logic [mom_pkg::SUM_W-1:0]      sum_x_o,
  output logic [mom_pkg::SUM_W-1:0]      sum_y_o,
  output logic [mom_pkg::SUM_W-1:0]      sum_t_o
);
  import mom_pkg::*;

  logic signed [ACC_W-1:0] acc_x, acc_y, acc_t;

  function automatic logic [SUM_W-1:0] sat(input logic signed [ACC_W-1:0] a);
    if (a > SUM_MAX_A) begin
      return {1'b0, {(SUM_W - 1){1'b1}}};
    end else if (a < SUM_MIN_A) begin
      return {1'b1, {(SUM_W - 1){1'b0}}};
    end
    return a[SUM_W-1:0];
  endfunction

  always_comb begin
    acc_x = ACC_W'(view_i.joy_vel.x);
    acc_y = ACC_W'(view_i.joy_vel.y);
    acc_t = ACC_W'(view_i.joy_vel.t);
    if (view_i.api_en) begin
      acc_x = acc_x + ACC_W'(view_i.api_vel.x);
      acc_y = acc_y + ACC_W'(view_i.api_vel.y);
      acc_t = acc_t + ACC_W'(view_i.api_vel.t);
    end
    for (int k = 0; k < PROGRAM_SLOTS; k++) begin
      if (view_i.slot_en[k]) begin
        acc_x = acc_x + ACC_W'(view_i.slot_vel[k].x);
        acc_y = acc_y + ACC_W'(view_i.slot_vel[k].y);
        acc_t = acc_t + ACC_W'(view_i.slot_vel[k].t);
      end
    end
  end

  assign sum_x_o = sat(acc_x);
  assign sum_y_o = sat(acc_y);
  assign sum_t_o = sat(acc_t);

endmodule

`default_nettype wire

// ===== hw/rtl/mom_checker.sv =====
// Port-level checks of the motion order mixer and their bind.
`default_nettype none
`include "motion_order_mixer_defines.svh"

module mom_checker (
  input wire logic                            clk_i,
  input wire logic                            rst_ni,
  input wire logic                            s_axis_tvalid,
  input wire logic                            s_axis_tready,
  input wire logic [mom_pkg::IN_TDATA_W-1:0]  s_axis_tdata,
  input wire logic [mom_pkg::IN_TUSER_W-1:0]  s_axis_tuser,
  input wire logic                            m_axis_tvalid,
  input wire logic                            m_axis_tready,
  input wire logic [mom_pkg::OUT_TDATA_W-1:0] m_axis_tdata
);
  import mom_pkg::*;

  // Hold a stalled result.
  `MOM_ASSERT_NEXT(a_out_hold, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata), "stalled result changed")
  // Drop input ready only behind a stalled result.
  `MOM_ASSERT_SAME(a_ready_low, !s_axis_tready, m_axis_tvalid && !m_axis_tready, "ready low without output stall")
  // Report only slots that exist.
  `MOM_ASSERT_SAME(a_slot_range, m_axis_tvalid, m_axis_tdata[60:57] < PROGRAM_SLOTS, "slot index out of range")
  // Keep the padding bits above key_matched at zero.
  `MOM_ASSERT_SAME(a_pad_zero, m_axis_tvalid, m_axis_tdata[63:62] == 2'b00, "result padding not zero")

endmodule

bind motion_order_mixer mom_checker u_mom_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .s_axis_tvalid (s_axis_tvalid),
  .s_axis_tready (s_axis_tready),
  .s_axis_tdata  (s_axis_tdata),
  .s_axis_tuser  (s_axis_tuser),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata)
);

`default_nettype wire
